[hw/rtl/u2c_pkg.sv]
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types, constants and the code point to Windows-1252 map.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [7:0]      QMARK     = 8'h3F;
  localparam logic [CP_W-1:0] CP_QMARK  = 21'h00003F;
  localparam logic [CP_W-1:0] C1_LO     = 21'h000080;
  localparam logic [CP_W-1:0] C1_HI     = 21'h00009F;
  localparam logic [CP_W-1:0] LATIN1_HI = 21'h0000FF;

  // One finished code point on its way to the back end.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } u2c_item_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } u2c_qstat_t;

  // Front end status.
  typedef struct packed {
    logic busy;   // inside a multi-byte sequence
  } u2c_fstat_t;

  function automatic logic [7:0] to_cp1252(input logic [CP_W-1:0] cp);
    logic [7:0] res;
    if (cp >= C1_LO && cp <= C1_HI) begin
      res = QMARK;
    end else if (cp <= LATIN1_HI) begin
      res = cp[7:0];
    end else begin
      unique case (cp)
        21'h0020AC: res = 8'd128;
        21'h00201A: res = 8'd130;
        21'h000192: res = 8'd131;
        21'h00201E: res = 8'd132;
        21'h002026: res = 8'd133;
        21'h002020: res = 8'd134;
        21'h002021: res = 8'd135;
        21'h0002C6: res = 8'd136;
        21'h002030: res = 8'd137;
        21'h000160: res = 8'd138;
        21'h002039: res = 8'd139;
        21'h000152: res = 8'd140;
        21'h00017D: res = 8'd142;
        21'h002018: res = 8'd145;
        21'h002019: res = 8'd146;
        21'h00201C: res = 8'd147;
        21'h00201D: res = 8'd148;
        21'h002022: res = 8'd149;
        21'h002013: res = 8'd150;
        21'h002014: res = 8'd151;
        21'h0002DC: res = 8'd152;
        21'h002122: res = 8'd153;
        21'h000161: res = 8'd154;
        21'h00203A: res = 8'd155;
        21'h000153: res = 8'd156;
        21'h00017E: res = 8'd158;
        21'h000178: res = 8'd159;
        default:    res = QMARK;
      endcase
    end
    return res;
  endfunction

endpackage

[hw/rtl/u2c_front.sv]
// ----------------------------------------------------------------------------
// u2c_front
// UTF-8 byte decoder: assembles code points and pushes finished ones.
// ----------------------------------------------------------------------------
module u2c_front
  import u2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic       q_full,
  output logic       push,
  output u2c_item_t  push_item,
  output u2c_fstat_t fstat
);

  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      remain_r, remain_nxt;
  logic [CP_W-1:0] cp_new;
  logic [1:0]      rem_new;
  logic            accept;
  logic            done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (remain_r != 2'd0) begin
      cp_new  = {partial_r[CP_W-7:0], in_byte[5:0]};
      rem_new = remain_r - 2'd1;
    end else if (in_byte[7:5] == 3'b110) begin
      cp_new  = CP_W'(in_byte[4:0]);
      rem_new = 2'd1;
    end else if (in_byte[7:4] == 4'b1110) begin
      cp_new  = CP_W'(in_byte[3:0]);
      rem_new = 2'd2;
    end else if (in_byte[7:3] == 5'b11110) begin
      cp_new  = CP_W'(in_byte[2:0]);
      rem_new = 2'd3;
    end else begin
      // ASCII or stray byte: complete on its own
      cp_new  = CP_W'(in_byte);
      rem_new = 2'd0;
    end
  end

  assign done = (rem_new == 2'd0);

  // end inside a sequence gives '?', which the map passes unchanged
  assign push           = accept && (done || in_end);
  assign push_item.cp   = done ? cp_new : CP_QMARK;
  assign push_item.last = in_end;

  always_comb begin
    partial_nxt = partial_r;
    remain_nxt  = remain_r;
    if (accept) begin
      if (done || in_end) begin
        partial_nxt = '0;
        remain_nxt  = 2'd0;
      end else begin
        partial_nxt = cp_new;
        remain_nxt  = rem_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      remain_r  <= 2'd0;
    end else begin
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
    end
  end

  assign fstat.busy = (remain_r != 2'd0);

endmodule

[hw/rtl/u2c_queue.sv]
// ----------------------------------------------------------------------------
// u2c_queue
// Small FIFO of decoded code points between front and back end.
// ----------------------------------------------------------------------------
module u2c_queue
  import u2c_pkg::*;
#(
  parameter int unsigned DEPTH = 2
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  u2c_item_t push_item,
  input  logic      pop,
  output u2c_item_t head,
  output u2c_qstat_t qstat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  u2c_item_t mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  assign head        = mem[rd_ptr_r];
  assign qstat.full  = (count_r == FULL_CNT);
  assign qstat.empty = (count_r == '0);

endmodule

[hw/rtl/u2c_back.sv]
// ----------------------------------------------------------------------------
// u2c_back
// Maps queued code points to Windows-1252 into the output register.
// ----------------------------------------------------------------------------
module u2c_back
  import u2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  u2c_item_t  head,
  input  u2c_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_end_r;
  logic       load;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && !qstat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= to_cp1252(head.cp);
      out_end_r  <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_end   = out_end_r;

endmodule

[hw/rtl/utf8_to_cp1252_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_cp1252_transcoder
// UTF-8 byte stream in, one Windows-1252 byte out per finished code point.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one UTF-8 byte per item, in_end marks
// the last byte of a string. Output channel (out_valid/out_ready): one
// Windows-1252 byte per finished code point, out_end marks the end.
// Lead and continuation bytes of a multi-byte sequence give no output until
// the sequence completes; a string that ends mid-sequence gives '?' + end.
// Throughput: one item per cycle, sustained, while the receiver keeps up.
// The decoder writes each finished code point into the queue at the accepting
// edge; the code map then loads it into the output register, raising out_valid.
// When the receiver stalls, the queue (QUEUE_DEPTH entries) and the output
// register absorb items; in_ready drops only once the queue is full.
// Reset (rst_n low, synchronous) clears the decoder state, empties the queue
// and drops out_valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_transcoder
  import u2c_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end
);

  logic       push;
  logic       pop;
  u2c_item_t  push_item;
  u2c_item_t  head;
  u2c_qstat_t qstat;
  u2c_fstat_t fstat;

  // front: byte decoder, holds the partial code point
  u2c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_end    (in_end),
    .q_full    (qstat.full),
    .push      (push),
    .push_item (push_item),
    .fstat     (fstat)
  );

  // decouples the decoder from the output stall
  u2c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: code map and output register
  u2c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_end   (out_end)
  );

`ifndef ASSERT_OFF
  // an item with the end mark always leaves the decoder idle
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end) |=> !fstat.busy)
    else $error("decoder still in a sequence after end item");

  // a queued item moves into a free output register at once
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!qstat.empty && (!out_valid || out_ready)) |=> out_valid)
    else $error("queued item not moved to output");

  // queue can never be both full and empty
  a_qstat: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue flags inconsistent");

  // reset empties the queue and the output register and leaves the decoder idle
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && qstat.empty && !fstat.busy))
    else $error("state not cleared by reset");
`endif

endmodule

[test/utf8_to_cp1252_transcoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_cp1252_transcoder_tb
// Drives UTF-8 bytes into the transcoder and checks every Windows-1252 byte
// that comes out against a predictor running alongside. Directed items cover
// stray bytes, each sequence length, unchecked continuations and end marks;
// a random stream of mostly well-formed characters follows, mixed with cut,
// corrupted and noise sequences. The sender idles in bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module utf8_to_cp1252_transcoder_tb
  import u2c_pkg::*;
();

  localparam int ITEMS_TARGET = 500;

  // One expected output item.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cp1252_char_t;

  // Kinds of random input sequences.
  typedef enum int {
    SEQ_GOOD,      // well-formed character, maybe overlong
    SEQ_CUT,       // sequence stopped short, with or without end mark
    SEQ_BAD_CONT,  // continuation bytes with random top bits
    SEQ_NOISE      // one random byte
  } seq_kind_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_end    = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_end;

  // Predictor state: code point under assembly, continuation bytes left.
  logic [CP_W-1:0] cp_acc    = '0;
  logic [1:0]      cont_left = '0;

  cp1252_char_t pending_chars[$];

  int bytes_sent   = 0;
  int chars_seen   = 0;
  int ends_seen    = 0;
  int errors       = 0;
  int burst_left   = 0;
  int ready_left   = 0;
  logic ready_hold = 1'b0;

  utf8_to_cp1252_transcoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_end   (in_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_end  (out_end)
  );

  always #5 clk = ~clk;

  // Code point behind each slot of the 0x80..0x9F row of Windows-1252;
  // zero marks the five slots left unassigned.
  function automatic logic [CP_W-1:0] high_row_cp(input int idx);
    case (idx)
      'h00: high_row_cp = 21'h0020AC;
      'h02: high_row_cp = 21'h00201A;
      'h03: high_row_cp = 21'h000192;
      'h04: high_row_cp = 21'h00201E;
      'h05: high_row_cp = 21'h002026;
      'h06: high_row_cp = 21'h002020;
      'h07: high_row_cp = 21'h002021;
      'h08: high_row_cp = 21'h0002C6;
      'h09: high_row_cp = 21'h002030;
      'h0A: high_row_cp = 21'h000160;
      'h0B: high_row_cp = 21'h002039;
      'h0C: high_row_cp = 21'h000152;
      'h0E: high_row_cp = 21'h00017D;
      'h11: high_row_cp = 21'h002018;
      'h12: high_row_cp = 21'h002019;
      'h13: high_row_cp = 21'h00201C;
      'h14: high_row_cp = 21'h00201D;
      'h15: high_row_cp = 21'h002022;
      'h16: high_row_cp = 21'h002013;
      'h17: high_row_cp = 21'h002014;
      'h18: high_row_cp = 21'h0002DC;
      'h19: high_row_cp = 21'h002122;
      'h1A: high_row_cp = 21'h000161;
      'h1B: high_row_cp = 21'h00203A;
      'h1C: high_row_cp = 21'h000153;
      'h1E: high_row_cp = 21'h00017E;
      'h1F: high_row_cp = 21'h000178;
      default: high_row_cp = '0;
    endcase
  endfunction

  // Code point to Windows-1252: C1 controls and anything off the map are '?'.
  function automatic logic [7:0] cp1252_of(input logic [CP_W-1:0] cp);
    logic [7:0] ch;
    ch = QMARK;
    if (cp <= LATIN1_HI && !(cp >= C1_LO && cp <= C1_HI)) begin
      ch = cp[7:0];
    end else if (cp > LATIN1_HI) begin
      for (int i = 0; i < 32; i++) begin
        if (high_row_cp(i) == cp) ch = 8'h80 + 8'(i);
      end
    end
    return ch;
  endfunction

  // Advance the predictor by one accepted byte; queue the char it yields.
  function automatic void transcode_byte(input logic [7:0] b, input logic e);
    cp1252_char_t c;
    if (cont_left != 2'd0) begin
      // continuation: top bits are not looked at
      cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
    end else if (b[7:5] == 3'b110) begin
      cp_acc    = CP_W'(b[4:0]);
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc    = CP_W'(b[3:0]);
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc    = CP_W'(b[2:0]);
      cont_left = 2'd3;
    end else begin
      // ASCII or stray byte stands for itself
      cp_acc    = CP_W'(b);
      cont_left = 2'd0;
    end

    if (cont_left == 2'd0) begin
      c.ch   = cp1252_of(cp_acc);
      c.last = e;
      pending_chars = {pending_chars, c};
      cp_acc = '0;
    end else if (e) begin
      // string ended inside a sequence
      c.ch      = QMARK;
      c.last    = 1'b1;
      pending_chars = {pending_chars, c};
      cp_acc    = '0;
      cont_left = 2'd0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ERROR: %s", $realtime, what);
    errors++;
  endtask

  // Send one byte. The sender runs in bursts; between bursts valid drops
  // for a random gap (zero gap merges two bursts).
  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                               : $urandom_range(0, 3);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_end   <= e;
    do @(posedge clk); while (!in_ready);
    transcode_byte(b, e);
    bytes_sent++;
  endtask

  // Encode cp in len bytes (overlong allowed) and send bytes 0..stop_at.
  // end_flag goes on the last byte sent; corrupt scrambles the top bits
  // of continuation bytes.
  task automatic send_char(input logic [CP_W-1:0] cp, input int len,
                           input int stop_at, input logic end_flag,
                           input logic corrupt);
    logic [7:0] b;
    for (int k = 0; k <= stop_at; k++) begin
      if (k == 0) begin
        case (len)
          1:       b = {1'b0, cp[6:0]};
          2:       b = {3'b110, cp[10:6]};
          3:       b = {4'b1110, cp[15:12]};
          default: b = {5'b11110, cp[20:18]};
        endcase
      end else begin
        b = {2'b10, cp[6*(len-1-k) +: 6]};
        if (corrupt) b[7:6] = 2'($urandom_range(0, 3));
      end
      send_byte(b, end_flag && (k == stop_at));
    end
  endtask

  // ASCII and stray bytes outside any sequence.
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);  // C1 range gives '?'
    send_byte(8'h9F, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hBF, 1'b0);  // stray continuation passes through
    send_byte(8'hF8, 1'b0);  // not a lead byte: taken as itself
    send_byte(8'hFF, 1'b0);
  endtask

  // One sequence of each multi-byte length, mapped and unmapped.
  task automatic test_sequences();
    send_byte(8'hC2, 1'b0);  // U+0080 -> '?'
    send_byte(8'h80, 1'b0);
    send_char(21'h0020AC, 3, 2, 1'b0, 1'b0);  // euro sign
    send_char(21'h002122, 3, 2, 1'b0, 1'b0);  // trade mark
    send_byte(8'hF7, 1'b0);  // largest 21-bit value -> '?'
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // Continuation with top bits 00 still contributes its low six bits.
  task automatic test_unchecked_continuation();
    send_byte(8'hC5, 1'b0);
    send_byte(8'h12, 1'b0);  // U+0152 -> 0x8C
  endtask

  // End mark on a complete char and inside a sequence.
  task automatic test_end_marks();
    send_byte(8'h41, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);  // cut short: '?' with end
  endtask

  // Mostly well-formed characters with random content, the rest broken.
  task automatic test_random_stream();
    logic [CP_W-1:0] cp;
    int              len;
    int              idx;
    int              pick;
    seq_kind_t       kind;
    while (bytes_sent < ITEMS_TARGET) begin
      case ($urandom_range(0, 4))
        0: cp = CP_W'($urandom_range('h0, 'h7F));
        1: cp = CP_W'($urandom_range('h80, 'hFF));
        2: begin
          do idx = $urandom_range(0, 31); while (high_row_cp(idx) == '0);
          cp = high_row_cp(idx);
        end
        3: cp = CP_W'($urandom_range('h100, 'hFFFF));
        default: cp = CP_W'($urandom_range('h10000, 'h1FFFFF));
      endcase
      if (cp < 'h80) len = 1;
      else if (cp < 'h800) len = 2;
      else if (cp < 'h10000) len = 3;
      else len = 4;
      if ($urandom_range(0, 7) == 0) len = $urandom_range(len, 4);

      pick = $urandom_range(0, 9);
      if (pick < 7) kind = SEQ_GOOD;
      else if (pick == 7) kind = SEQ_CUT;
      else if (pick == 8) kind = SEQ_BAD_CONT;
      else kind = SEQ_NOISE;

      case (kind)
        SEQ_GOOD: begin
          send_char(cp, len, len - 1, $urandom_range(0, 11) == 0, 1'b0);
        end
        SEQ_CUT: begin
          if (len == 1) len = $urandom_range(2, 4);
          send_char(cp, len, $urandom_range(0, len - 2),
                    $urandom_range(0, 1) == 1, 1'b0);
        end
        SEQ_BAD_CONT: begin
          if (len == 1) len = $urandom_range(2, 4);
          send_char(cp, len, len - 1, $urandom_range(0, 11) == 0, 1'b1);
        end
        default: begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      endcase
    end
  endtask

  // Receiver: runs of ready high (long) and low (short), drawn afresh
  // each time a run runs out.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_hold = ($urandom_range(0, 3) != 0);
      ready_left = ready_hold ? $urandom_range(1, 40) : $urandom_range(1, 6);
    end
    ready_left--;
    out_ready <= ready_hold;
  end

  // Every output item is matched against the oldest expected char.
  always @(posedge clk) begin
    cp1252_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item byte %h end %b",
                                  out_byte, out_end));
      end else begin
        want = pending_chars.pop_front();
        if (out_byte !== want.ch)
          report_mismatch($sformatf("out_byte got %h want %h", out_byte, want.ch));
        if (out_end !== want.last)
          report_mismatch($sformatf("out_end got %b want %b (byte %h)",
                                    out_end, want.last, want.ch));
        chars_seen++;
        if (want.last) ends_seen++;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_bytes();
    test_sequences();
    test_unchecked_continuation();
    test_end_marks();
    test_random_stream();

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching to catch anything extra
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d chars never came out", pending_chars.size()));

    $display("Covered %0d UTF-8 bytes in, %0d Windows-1252 bytes out, %0d end marks.",
             bytes_sent, chars_seen, ends_seen);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("utf8_to_cp1252_transcoder_tb OK");
    end else begin
      $display("utf8_to_cp1252_transcoder_tb NOT OK");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d chars outstanding", pending_chars.size());
    $display("utf8_to_cp1252_transcoder_tb NOT OK");
    $finish;
  end

endmodule

[files.f]
hw/rtl/u2c_pkg.sv
hw/rtl/u2c_front.sv
hw/rtl/u2c_queue.sv
hw/rtl/u2c_back.sv
hw/rtl/utf8_to_cp1252_transcoder.sv
test/utf8_to_cp1252_transcoder_tb.sv
